FILE: rtl/bra_pkg.sv
package bra_pkg;

	// Sizes of the allocator.
	localparam int NUM_CUST = 5;
	localparam int NUM_RES  = 3;
	localparam int UNIT_W   = 8;
	localparam int CUST_AW  = $clog2(NUM_CUST);
	localparam int CNT_W    = $clog2(NUM_CUST + 1);

	// Configuration register indexes and port widths.
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam logic [1:0] REG_POOL_0 = 2'd0;
	localparam logic [1:0] REG_POOL_1 = 2'd1;
	localparam logic [1:0] REG_POOL_2 = 2'd2;

	typedef logic [UNIT_W-1:0] unit_t;
	typedef unit_t [NUM_RES-1:0] row_t;

	// Operation codes.
	typedef enum logic [1:0] {
		FUNC_REQUEST = 2'd0,
		FUNC_RELEASE = 2'd1,
		FUNC_CLAIM   = 2'd2,
		FUNC_NONE    = 2'd3
	} func_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_DONE        = 3'd0,
		ST_EXCEED_NEED = 3'd1,
		ST_NOT_AVAIL   = 3'd2,
		ST_UNSAFE      = 3'd3,
		ST_OVER_REL    = 3'd4,
		ST_BAD_CLAIM   = 3'd5
	} status_t;

	// Controller states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_SCAN,
		S_OUT
	} state_t;

	// One operation.
	typedef struct packed {
		logic [1:0] func;
		logic [2:0] customer;
		logic [7:0] amount_0;
		logic [7:0] amount_1;
		logic [7:0] amount_2;
	} op_t;

	// One result.
	typedef struct packed {
		logic [2:0] status;
		logic [7:0] avail_0;
		logic [7:0] avail_1;
		logic [7:0] avail_2;
	} res_t;

endpackage

FILE: rtl/bankers_resource_allocator.sv
// Deadlock-avoiding resource allocator (Banker's algorithm).
// The req channel carries one operation per transfer: a request, a release or a
// maximum claim for one customer. The rsp channel returns one result per
// operation: a status code and the available units of each resource type.
// Both channels use valid/stall; a transfer happens when valid is high and
// stall is low. The pool totals are written through the APB port; the user must
// write them only while idle, as the block itself does not enforce this.
// Release, claim and rejected operations go through S_READ and S_OUT.
// A request that passes its checks runs the safety scan: the customer rows are
// read from the held and need memories one per cycle, round robin, until all
// customers can finish or a full round makes no progress. That scan evaluates
// between 5 and 22 rows, one from each read of the single memory read port.
// One operation is handled at a time; the next one is taken once the result is
// in the output register, even while the receiver still stalls it.
// Reset clears the pool totals, the units in use and the row valid bits, so
// every customer starts with nothing held and nothing claimed.
// A stalled result holds until it is taken.
module bankers_resource_allocator (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  bra_pkg::op_t           req,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output bra_pkg::res_t          rsp,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [bra_pkg::PADDR_W-1:0] paddr,
	input  logic [bra_pkg::PDATA_W-1:0] pwdata,
	output logic [bra_pkg::PDATA_W-1:0] prdata,
	output logic                   pready
);
	import bra_pkg::*;

	// Storage.
	row_t                held_mem [NUM_CUST];
	row_t                need_mem [NUM_CUST];
	logic [NUM_CUST-1:0] row_vld_q;
	row_t                rd_held_q;
	row_t                rd_need_q;
	logic                rd_vld_q;
	logic [CUST_AW-1:0]  rd_addr;

	unit_t               pool_q [NUM_RES];
	row_t                use_q;

	// Control and working registers.
	state_t              state_q, state_d;
	op_t                 op_q;
	status_t             status_q, status_d;
	row_t                tent_held_q, tent_need_q, tent_use_q;
	row_t                work_q;
	logic [NUM_CUST-1:0] done_q;
	logic [CNT_W-1:0]    since_q;
	logic [CUST_AW-1:0]  scan_c_q;
	logic                eval_vld_s1;
	logic [CUST_AW-1:0]  eval_c_s1;
	logic                rsp_valid_q;
	res_t                rsp_q;

	// Combinational control.
	row_t                amt, avail, h_cur, n_cur, e_h, e_n;
	row_t                wr_held, wr_need, use_d, work_d;
	logic                mem_we, use_we, scan_start, eval_step, load_rsp;
	logic                cust_ok, exceed_need, not_avail, over_rel, bad_claim, fits, take;
	logic [CUST_AW-1:0]  cust_idx;
	logic [NUM_CUST-1:0] done_d;
	logic [CNT_W-1:0]    since_d;
	logic                cfg_we;

	assign amt[0] = op_q.amount_0;
	assign amt[1] = op_q.amount_1;
	assign amt[2] = op_q.amount_2;
	assign cust_ok  = ({1'b0, op_q.customer} < (CUST_AW + 1)'(NUM_CUST));
	assign cust_idx = CUST_AW'(op_q.customer);

	// Available units saturate at zero when the pool was lowered below use.
	always_comb begin
		for (int r = 0; r < NUM_RES; r++) begin
			avail[r] = (pool_q[r] > use_q[r]) ? unit_t'(pool_q[r] - use_q[r]) : '0;
		end
	end

	// A row that was never written reads as zero.
	assign h_cur = rd_vld_q ? rd_held_q : '0;
	assign n_cur = rd_vld_q ? rd_need_q : '0;

	// Checks of the operation against the customer row.
	always_comb begin
		exceed_need = 1'b0;
		not_avail   = 1'b0;
		over_rel    = 1'b0;
		bad_claim   = 1'b0;
		for (int r = 0; r < NUM_RES; r++) begin
			if (amt[r] > n_cur[r]) exceed_need = 1'b1;
			if (amt[r] > avail[r]) not_avail = 1'b1;
			if (amt[r] > h_cur[r]) over_rel = 1'b1;
			if (h_cur[r] != '0 || amt[r] > pool_q[r]) bad_claim = 1'b1;
		end
	end

	// Safety scan step: the requesting customer is seen with its tentative row.
	always_comb begin
		e_h  = (eval_c_s1 == cust_idx) ? tent_held_q : h_cur;
		e_n  = (eval_c_s1 == cust_idx) ? tent_need_q : n_cur;
		fits = 1'b1;
		for (int r = 0; r < NUM_RES; r++) begin
			if (e_n[r] > work_q[r]) fits = 1'b0;
		end
		take   = !done_q[eval_c_s1] && fits;
		done_d = done_q;
		work_d = work_q;
		if (take) begin
			done_d[eval_c_s1] = 1'b1;
			for (int r = 0; r < NUM_RES; r++) begin
				work_d[r] = unit_t'(work_q[r] + e_h[r]);
			end
		end
		since_d = take ? '0 : CNT_W'(since_q + 1'b1);
	end

	// Next state, status and write-back control.
	always_comb begin
		state_d    = state_q;
		status_d   = status_q;
		mem_we     = 1'b0;
		use_we     = 1'b0;
		scan_start = 1'b0;
		eval_step  = 1'b0;
		load_rsp   = 1'b0;
		wr_held    = h_cur;
		wr_need    = n_cur;
		use_d      = use_q;
		rd_addr    = '0;
		case (state_q)
			S_IDLE: begin
				rd_addr = ({1'b0, req.customer} < (CUST_AW + 1)'(NUM_CUST)) ?
					CUST_AW'(req.customer) : '0;
				if (req_valid) state_d = S_READ;
			end
			S_READ: begin
				state_d  = S_OUT;
				status_d = ST_DONE;
				if (!cust_ok) begin
					if (op_q.func == FUNC_REQUEST) status_d = ST_EXCEED_NEED;
					else if (op_q.func == FUNC_RELEASE) status_d = ST_OVER_REL;
					else if (op_q.func == FUNC_CLAIM) status_d = ST_BAD_CLAIM;
				end else begin
					case (op_q.func)
						FUNC_REQUEST: begin
							if (exceed_need) status_d = ST_EXCEED_NEED;
							else if (not_avail) status_d = ST_NOT_AVAIL;
							else begin
								scan_start = 1'b1;
								state_d    = S_SCAN;
							end
						end
						FUNC_RELEASE: begin
							if (over_rel) status_d = ST_OVER_REL;
							else begin
								mem_we = 1'b1;
								use_we = 1'b1;
								for (int r = 0; r < NUM_RES; r++) begin
									wr_held[r] = unit_t'(h_cur[r] - amt[r]);
									wr_need[r] = unit_t'(n_cur[r] + amt[r]);
									use_d[r]   = unit_t'(use_q[r] - amt[r]);
								end
							end
						end
						FUNC_CLAIM: begin
							if (bad_claim) status_d = ST_BAD_CLAIM;
							else begin
								mem_we  = 1'b1;
								wr_need = amt;
							end
						end
						default: status_d = ST_DONE;
					endcase
				end
			end
			S_SCAN: begin
				rd_addr = scan_c_q;
				if (eval_vld_s1) begin
					eval_step = 1'b1;
					if (&done_d) begin
						// Every customer can finish: commit the allocation.
						state_d  = S_OUT;
						status_d = ST_DONE;
						mem_we   = 1'b1;
						use_we   = 1'b1;
						wr_held  = tent_held_q;
						wr_need  = tent_need_q;
						use_d    = tent_use_q;
					end else if (since_d == CNT_W'(NUM_CUST)) begin
						// A full round without progress: the state would be unsafe.
						state_d  = S_OUT;
						status_d = ST_UNSAFE;
					end
				end
			end
			S_OUT: begin
				if (!rsp_valid_q || !rsp_stall) begin
					load_rsp = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Row memories: one read and one write port each, read data registered.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			held_mem[cust_idx] <= wr_held;
			need_mem[cust_idx] <= wr_need;
		end
		rd_held_q <= held_mem[rd_addr];
		rd_need_q <= need_mem[rd_addr];
	end

	// Row valid bits and the registered valid of the row being read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (mem_we) row_vld_q[cust_idx] <= 1'b1;
			rd_vld_q <= row_vld_q[rd_addr];
		end
	end

	// Units in use and the scan control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_q       <= '0;
			eval_vld_s1 <= 1'b0;
			scan_c_q    <= '0;
			since_q     <= '0;
			done_q      <= '0;
			status_q    <= ST_DONE;
		end else begin
			if (use_we) use_q <= use_d;
			status_q    <= status_d;
			eval_vld_s1 <= (state_q == S_SCAN) && (state_d == S_SCAN);
			if (scan_start) begin
				scan_c_q <= '0;
				since_q  <= '0;
				done_q   <= '0;
			end else if (state_q == S_SCAN) begin
				scan_c_q <= (scan_c_q == CUST_AW'(NUM_CUST - 1)) ? '0 :
					CUST_AW'(scan_c_q + 1'b1);
				if (eval_step) begin
					since_q <= since_d;
					done_q  <= done_d;
				end
			end
		end
	end

	// Operation capture, tentative allocation and scan work vector.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) op_q <= req;
		if (state_q == S_SCAN) eval_c_s1 <= scan_c_q;
		if (scan_start) begin
			for (int r = 0; r < NUM_RES; r++) begin
				tent_held_q[r] <= unit_t'(h_cur[r] + amt[r]);
				tent_need_q[r] <= unit_t'(n_cur[r] - amt[r]);
				tent_use_q[r]  <= unit_t'(use_q[r] + amt[r]);
				work_q[r]      <= unit_t'(avail[r] - amt[r]);
			end
		end else if (eval_step) begin
			work_q <= work_d;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_q.status  <= status_q;
			rsp_q.avail_0 <= avail[0];
			rsp_q.avail_1 <= avail[1];
			rsp_q.avail_2 <= avail[2];
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_RES; r++) pool_q[r] <= '0;
		end else if (cfg_we) begin
			case (paddr[3:2])
				REG_POOL_0: pool_q[0] <= pwdata[UNIT_W-1:0];
				REG_POOL_1: pool_q[1] <= pwdata[UNIT_W-1:0];
				REG_POOL_2: pool_q[2] <= pwdata[UNIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_POOL_0: prdata = PDATA_W'(pool_q[0]);
			REG_POOL_1: prdata = PDATA_W'(pool_q[1]);
			REG_POOL_2: prdata = PDATA_W'(pool_q[2]);
			default:    prdata = '0;
		endcase
	end

endmodule

FILE: test/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bra_pkg::*;

	// First register index past the pool totals; writes there are dropped.
	localparam logic [1:0] REG_NONE = 2'd3;

	// One line of the directed plan: a register write or an operation.
	typedef struct {
		bit          wr_reg;
		logic [1:0]  idx;
		logic [31:0] wdata;
		op_t         op;
		bit          known;
		res_t        want;
	} step_t;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	op_t                  req       = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	res_t                 rsp;
	logic                 psel      = 1'b0;
	logic                 penable   = 1'b0;
	logic                 pwrite    = 1'b0;
	logic [PADDR_W-1:0]   paddr     = '0;
	logic [PDATA_W-1:0]   pwdata    = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;

	// Shadow of the allocator state and of the pool registers.
	unit_t pool_mirror [NUM_RES]          = '{default: '0};
	unit_t held        [NUM_CUST][NUM_RES] = '{default: '{default: '0}};
	unit_t need        [NUM_CUST][NUM_RES] = '{default: '{default: '0}};
	unit_t in_use      [NUM_RES]          = '{default: '0};

	res_t pending_outcomes [$];
	int   errors       = 0;
	int   results_seen = 0;
	bit   steady       = 1'b0;

	bankers_resource_allocator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#10_000_000;
		$display("tb: FAIL");
		$finish;
	end

	// Units free for new requests; saturates when the pool was lowered below use.
	function automatic unit_t free_units(int r);
		return (pool_mirror[r] > in_use[r]) ? unit_t'(pool_mirror[r] - in_use[r]) : '0;
	endfunction

	// Safety scan: true when some order lets every customer finish.
	function automatic bit all_can_finish();
		int work     [NUM_RES];
		bit finished [NUM_CUST];
		bit moved;
		bit fits;
		for (int r = 0; r < NUM_RES; r++)
			work[r] = free_units(r);
		for (int c = 0; c < NUM_CUST; c++)
			finished[c] = 1'b0;
		for (int round = 0; round < NUM_CUST; round++) begin
			moved = 1'b0;
			for (int c = 0; c < NUM_CUST; c++) begin
				if (!finished[c]) begin
					fits = 1'b1;
					for (int r = 0; r < NUM_RES; r++)
						if (need[c][r] > work[r])
							fits = 1'b0;
					if (fits) begin
						for (int r = 0; r < NUM_RES; r++)
							work[r] += held[c][r];
						finished[c] = 1'b1;
						moved = 1'b1;
					end
				end
			end
			if (!moved)
				break;
		end
		for (int c = 0; c < NUM_CUST; c++)
			if (!finished[c])
				return 1'b0;
		return 1'b1;
	endfunction

	// Applies one operation to the shadow state and returns the outcome.
	function automatic res_t banker_outcome(op_t op);
		res_t    res;
		unit_t   amt [NUM_RES];
		int      c;
		status_t st;
		amt[0] = op.amount_0;
		amt[1] = op.amount_1;
		amt[2] = op.amount_2;
		c = op.customer;
		st = ST_DONE;
		if (func_t'(op.func) != FUNC_NONE && c >= NUM_CUST) begin
			// Unknown customer: reject with the code of the operation.
			if (func_t'(op.func) == FUNC_REQUEST)
				st = ST_EXCEED_NEED;
			else if (func_t'(op.func) == FUNC_RELEASE)
				st = ST_OVER_REL;
			else
				st = ST_BAD_CLAIM;
		end else begin
			case (func_t'(op.func))
				FUNC_REQUEST: begin
					for (int r = 0; r < NUM_RES; r++)
						if (amt[r] > need[c][r])
							st = ST_EXCEED_NEED;
					if (st == ST_DONE)
						for (int r = 0; r < NUM_RES; r++)
							if (amt[r] > free_units(r))
								st = ST_NOT_AVAIL;
					if (st == ST_DONE) begin
						// Grant tentatively, then roll back if the state is unsafe.
						for (int r = 0; r < NUM_RES; r++) begin
							in_use[r]  += amt[r];
							held[c][r] += amt[r];
							need[c][r] -= amt[r];
						end
						if (!all_can_finish()) begin
							for (int r = 0; r < NUM_RES; r++) begin
								in_use[r]  -= amt[r];
								held[c][r] -= amt[r];
								need[c][r] += amt[r];
							end
							st = ST_UNSAFE;
						end
					end
				end
				FUNC_RELEASE: begin
					for (int r = 0; r < NUM_RES; r++)
						if (amt[r] > held[c][r])
							st = ST_OVER_REL;
					if (st == ST_DONE)
						for (int r = 0; r < NUM_RES; r++) begin
							in_use[r]  -= amt[r];
							held[c][r] -= amt[r];
							need[c][r] += amt[r];
						end
				end
				FUNC_CLAIM: begin
					for (int r = 0; r < NUM_RES; r++)
						if (held[c][r] != 0 || amt[r] > pool_mirror[r])
							st = ST_BAD_CLAIM;
					if (st == ST_DONE)
						for (int r = 0; r < NUM_RES; r++)
							need[c][r] = amt[r];
				end
				default: ;
			endcase
		end
		res.status  = st;
		res.avail_0 = free_units(0);
		res.avail_1 = free_units(1);
		res.avail_2 = free_units(2);
		return res;
	endfunction

	function automatic bit take_break();
		return !steady && ($urandom_range(99) < 19);
	endfunction

	function automatic step_t op_row(func_t f, int c, int a0, int a1, int a2);
		step_t s;
		s.wr_reg      = 1'b0;
		s.idx         = '0;
		s.wdata       = '0;
		s.op.func     = f;
		s.op.customer = 3'(c);
		s.op.amount_0 = 8'(a0);
		s.op.amount_1 = 8'(a1);
		s.op.amount_2 = 8'(a2);
		s.known       = 1'b0;
		s.want        = '0;
		return s;
	endfunction

	function automatic step_t chk_row(func_t f, int c, int a0, int a1, int a2,
			status_t st, int v0, int v1, int v2);
		step_t s;
		s = op_row(f, c, a0, a1, a2);
		s.known        = 1'b1;
		s.want.status  = st;
		s.want.avail_0 = 8'(v0);
		s.want.avail_1 = 8'(v1);
		s.want.avail_2 = 8'(v2);
		return s;
	endfunction

	function automatic step_t reg_row(logic [1:0] idx, logic [31:0] data);
		step_t s;
		s = op_row(FUNC_NONE, 0, 0, 0, 0);
		s.wr_reg = 1'b1;
		s.idx    = idx;
		s.wdata  = data;
		return s;
	endfunction

	// Mostly well-formed traffic built from the current shadow state, some noise.
	function automatic op_t random_op();
		op_t op;
		int  c;
		int  pick;
		int  lim;
		bit  whole;
		unit_t amt [NUM_RES];
		if ($urandom_range(99) < 10) begin
			op.func     = 2'($urandom_range(3));
			op.customer = 3'($urandom_range(7));
			op.amount_0 = 8'($urandom_range(255));
			op.amount_1 = 8'($urandom_range(255));
			op.amount_2 = 8'($urandom_range(255));
			return op;
		end
		c = $urandom_range(NUM_CUST - 1);
		pick = $urandom_range(99);
		whole = ($urandom_range(2) == 0);
		for (int r = 0; r < NUM_RES; r++) begin
			if (pick < 15) begin
				amt[r] = unit_t'($urandom_range(pool_mirror[r]));
			end else if (pick < 65) begin
				lim = int'(need[c][r]);
				if ($urandom_range(1) && int'(free_units(r)) < lim)
					lim = int'(free_units(r));
				amt[r] = unit_t'($urandom_range(lim));
			end else begin
				amt[r] = whole ? held[c][r] : unit_t'($urandom_range(held[c][r]));
			end
		end
		if (pick < 15)
			op.func = FUNC_CLAIM;
		else if (pick < 65)
			op.func = FUNC_REQUEST;
		else
			op.func = FUNC_RELEASE;
		op.customer = 3'(c);
		op.amount_0 = amt[0];
		op.amount_1 = amt[1];
		op.amount_2 = amt[2];
		return op;
	endfunction

	// Presents one operation and records its outcome once the transfer happens.
	task automatic send_op(input op_t op, input bit known, input res_t want);
		res_t pred;
		while (take_break()) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req       <= op;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		pred = banker_outcome(op);
		pending_outcomes.push_back(known ? want : pred);
	endtask

	// Waits until every outcome has come back and the block has settled.
	task automatic drain();
		req_valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// Two-phase register write; the shadow copy follows at the write edge.
	task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_POOL_0: pool_mirror[0] = data[7:0];
			REG_POOL_1: pool_mirror[1] = data[7:0];
			REG_POOL_2: pool_mirror[2] = data[7:0];
			default: ;
		endcase
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Result side: random stall and comparison against the oldest expectation.
	always @(posedge clk) begin : rsp_side
		res_t want;
		if (rsp_valid && !rsp_stall) begin
			if (pending_outcomes.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("result %0d unexpected: status %0d avail %0d %0d %0d",
						results_seen, rsp.status, rsp.avail_0, rsp.avail_1, rsp.avail_2);
			end else begin
				want = pending_outcomes.pop_front();
				if (rsp.status !== want.status || rsp.avail_0 !== want.avail_0 ||
						rsp.avail_1 !== want.avail_1 || rsp.avail_2 !== want.avail_2) begin
					errors++;
					if (errors <= 10)
						$display("result %0d: want %0d %0d %0d %0d, got %0d %0d %0d %0d",
							results_seen, want.status, want.avail_0, want.avail_1,
							want.avail_2, rsp.status, rsp.avail_0, rsp.avail_1,
							rsp.avail_2);
				end
			end
			results_seen++;
		end
		rsp_stall <= take_break();
	end

	initial begin
		step_t       plan [$];
		logic [31:0] d;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty pools right after reset, unknown customers and the unused code.
		plan.push_back(chk_row(FUNC_REQUEST, 0, 0, 0, 0, ST_DONE, 0, 0, 0));
		plan.push_back(chk_row(FUNC_CLAIM, 0, 1, 0, 0, ST_BAD_CLAIM, 0, 0, 0));
		plan.push_back(chk_row(FUNC_REQUEST, 7, 0, 0, 0, ST_EXCEED_NEED, 0, 0, 0));
		plan.push_back(chk_row(FUNC_RELEASE, 5, 0, 0, 0, ST_OVER_REL, 0, 0, 0));
		plan.push_back(chk_row(FUNC_CLAIM, 6, 0, 0, 0, ST_BAD_CLAIM, 0, 0, 0));
		plan.push_back(chk_row(FUNC_NONE, 7, 255, 255, 255, ST_DONE, 0, 0, 0));
		// Pool of 10/5/7; upper data bits and the write past the last register are dropped.
		plan.push_back(reg_row(REG_POOL_0, 32'hFFFF_FF0A));
		plan.push_back(reg_row(REG_POOL_1, 32'h0000_0105));
		plan.push_back(reg_row(REG_POOL_2, 32'h8000_0007));
		plan.push_back(reg_row(REG_NONE, 32'h0000_00FF));
		plan.push_back(chk_row(FUNC_CLAIM, 0, 7, 5, 3, ST_DONE, 10, 5, 7));
		plan.push_back(chk_row(FUNC_CLAIM, 1, 3, 2, 2, ST_DONE, 10, 5, 7));
		plan.push_back(chk_row(FUNC_CLAIM, 2, 9, 0, 2, ST_DONE, 10, 5, 7));
		plan.push_back(chk_row(FUNC_CLAIM, 3, 2, 2, 2, ST_DONE, 10, 5, 7));
		plan.push_back(chk_row(FUNC_CLAIM, 4, 4, 3, 3, ST_DONE, 10, 5, 7));
		plan.push_back(op_row(FUNC_REQUEST, 0, 0, 1, 0));
		plan.push_back(op_row(FUNC_REQUEST, 1, 2, 0, 0));
		plan.push_back(op_row(FUNC_REQUEST, 2, 3, 0, 2));
		plan.push_back(op_row(FUNC_REQUEST, 3, 2, 1, 1));
		plan.push_back(op_row(FUNC_REQUEST, 4, 0, 0, 2));
		// Over need, not available, unsafe, claim while holding, over release.
		plan.push_back(op_row(FUNC_REQUEST, 1, 2, 0, 0));
		plan.push_back(op_row(FUNC_REQUEST, 0, 3, 3, 3));
		plan.push_back(op_row(FUNC_REQUEST, 4, 3, 3, 0));
		plan.push_back(op_row(FUNC_CLAIM, 0, 1, 1, 1));
		plan.push_back(op_row(FUNC_RELEASE, 3, 3, 0, 0));
		plan.push_back(op_row(FUNC_RELEASE, 3, 2, 1, 1));
		plan.push_back(op_row(FUNC_CLAIM, 3, 10, 5, 7));
		// Pool lowered below the units in use: free units saturate at zero.
		plan.push_back(reg_row(REG_POOL_0, 32'd2));
		plan.push_back(reg_row(REG_POOL_1, 32'd2));
		plan.push_back(reg_row(REG_POOL_2, 32'd2));
		plan.push_back(op_row(FUNC_REQUEST, 2, 0, 0, 0));
		plan.push_back(op_row(FUNC_RELEASE, 2, 3, 0, 2));
		// Full pools and the largest amounts.
		plan.push_back(reg_row(REG_POOL_0, 32'hFF));
		plan.push_back(reg_row(REG_POOL_1, 32'hFF));
		plan.push_back(reg_row(REG_POOL_2, 32'hFF));
		plan.push_back(op_row(FUNC_CLAIM, 3, 255, 255, 255));
		plan.push_back(op_row(FUNC_REQUEST, 3, 255, 255, 255));
		plan.push_back(op_row(FUNC_RELEASE, 0, 255, 255, 255));

		foreach (plan[i]) begin
			if (plan[i].wr_reg) begin
				drain();
				reg_write(plan[i].idx, plan[i].wdata);
			end else
				send_op(plan[i].op, plan[i].known, plan[i].want);
		end

		// Random traffic in phases, each with its own pool setting.
		for (int ph = 0; ph < 5; ph++) begin
			drain();
			for (int r = 0; r < NUM_RES; r++) begin
				d = $urandom();
				case (ph)
					0: d[7:0] = 8'hFF;
					1: d[7:0] = 8'($urandom_range(1, 15));
					2: d[7:0] = 8'($urandom_range(0, 255));
					default: d[7:0] = (r == ph - 3) ? 8'h00 : 8'($urandom_range(4, 40));
				endcase
				reg_write(2'(r), d);
			end
			if (ph == 2)
				reg_write(REG_NONE, $urandom());
			for (int k = 0; k < 400; k++) begin
				steady = (ph == 2 && k >= 100);
				send_op(random_op(), 1'b0, '0);
			end
			steady = 1'b0;
		end

		drain();
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

FILE: bankers_resource_allocator.f
rtl/bra_pkg.sv
rtl/bankers_resource_allocator.sv
test/tb.sv
